// File: src/fhla_pkg.sv
// ----------------------------------------------------------------------------
// fhla_pkg: shared types and constants of the free hole list allocator
// Word layouts of the request and response channels, fit mode and command
// codes, sequencer states and the status bundle from the list engine.
// ----------------------------------------------------------------------------
package fhla_pkg;

	localparam int CAPACITY_DEF     = 64;
	localparam int HEADER_BYTES_DEF = 8;

	localparam int OFF_W   = 32;
	localparam int SIZE_W  = 32;
	localparam int COUNT_W = 7;
	localparam int MODE_W  = 2;

	// Fit modes; the fourth code places nothing into a nonempty list
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd0;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd1;
	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd2;

	localparam logic CMD_RELEASE  = 1'b0;
	localparam logic CMD_ALLOCATE = 1'b1;

	typedef struct packed {
		logic              command;
		logic [OFF_W-1:0]  block_offset;
		logic [SIZE_W-1:0] block_size;
	} fhla_req_t;

	typedef struct packed {
		logic               found;
		logic [OFF_W-1:0]   result_offset;
		logic               dropped;
		logic [COUNT_W-1:0] hole_count;
	} fhla_rsp_t;

	typedef struct packed {
		logic idle;
		logic done;
	} fhla_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUT_START,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHUP_RD,
		ST_SHUP_WR,
		ST_PUT_WR,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHDN_RD,
		ST_SHDN_WR,
		ST_DONE
	} fhla_state_t;

endpackage

// File: src/fhla_engine.sv
// ----------------------------------------------------------------------------
// fhla_engine: hole list storage and sequencer
// Holds the hole list in a single-port-write, registered-read memory and
// walks it with one shared size comparator: binary search, linear scan,
// and entry-by-entry shifts (a read state and a write state per entry) for insert and remove.
// ----------------------------------------------------------------------------
module fhla_engine #(
	parameter int CAPACITY     = fhla_pkg::CAPACITY_DEF,
	parameter int HEADER_BYTES = fhla_pkg::HEADER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  fhla_pkg::fhla_req_t             req,
	input  logic [fhla_pkg::MODE_W-1:0]     fit_mode,
	input  logic                            take,
	output fhla_pkg::fhla_stat_t            stat,
	output fhla_pkg::fhla_rsp_t             rsp
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int OFF_W  = fhla_pkg::OFF_W;
	localparam int SIZE_W = fhla_pkg::SIZE_W;
	localparam int ENT_W  = OFF_W + SIZE_W;
	localparam int CW     = fhla_pkg::COUNT_W;

	fhla_pkg::fhla_state_t state_q, state_d;

	logic [ENT_W-1:0]  mem [CAPACITY];
	logic [ENT_W-1:0]  rd_q;
	logic [IDX_W-1:0]  raddr, waddr;
	logic              we;
	logic [ENT_W-1:0]  wdata;

	logic              op_q;
	logic [OFF_W-1:0]  off_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  lo_q, hi_q, idx_q, pos_q, count_q;
	logic              found_q, dropped_q;
	logic [OFF_W-1:0]  res_off_q;

	logic [SIZE_W-1:0] rd_size;
	logic [OFF_W-1:0]  rd_off;
	logic [SIZE_W:0]   diff;
	logic              rd_lt, rd_gt, go_right, full;
	logic [CNT_W-1:0]  mid, idx_nx;
	logic [OFF_W-1:0]  new_off;

	// Shared comparator: stored size against the size under work
	assign rd_size  = rd_q[SIZE_W-1:0];
	assign rd_off   = rd_q[ENT_W-1:SIZE_W];
	assign diff     = {1'b0, rd_size} - {1'b0, size_q};
	assign rd_lt    = diff[SIZE_W];
	assign rd_gt    = !diff[SIZE_W] && (diff[SIZE_W-1:0] != '0);
	assign go_right = (fit_mode == fhla_pkg::FIT_WORST) ? rd_gt : rd_lt;

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_nx  = idx_q + 1'b1;
	assign new_off = rd_off + OFF_W'(HEADER_BYTES) + size_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fhla_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (req.command == fhla_pkg::CMD_ALLOCATE) ?
						fhla_pkg::ST_SCAN_RD : fhla_pkg::ST_PUT_START;
				end
			end
			fhla_pkg::ST_PUT_START: begin
				priority if (full) begin
					state_d = fhla_pkg::ST_DONE;
				end else if (count_q == '0) begin
					state_d = fhla_pkg::ST_PUT_WR;
				end else if (fit_mode == fhla_pkg::FIT_BEST ||
						fit_mode == fhla_pkg::FIT_WORST) begin
					state_d = fhla_pkg::ST_SRCH_RD;
				end else if (fit_mode == fhla_pkg::FIT_FIRST) begin
					state_d = fhla_pkg::ST_PUT_WR;
				end else begin
					state_d = fhla_pkg::ST_DONE;
				end
			end
			fhla_pkg::ST_SRCH_RD: begin
				state_d = (lo_q < hi_q) ? fhla_pkg::ST_SRCH_CMP : fhla_pkg::ST_SHUP_RD;
			end
			fhla_pkg::ST_SRCH_CMP: state_d = fhla_pkg::ST_SRCH_RD;
			fhla_pkg::ST_SHUP_RD: begin
				state_d = (idx_q > pos_q) ? fhla_pkg::ST_SHUP_WR : fhla_pkg::ST_PUT_WR;
			end
			fhla_pkg::ST_SHUP_WR: state_d = fhla_pkg::ST_SHUP_RD;
			fhla_pkg::ST_PUT_WR:  state_d = fhla_pkg::ST_DONE;
			fhla_pkg::ST_SCAN_RD: begin
				state_d = (idx_q < count_q) ? fhla_pkg::ST_SCAN_CMP : fhla_pkg::ST_DONE;
			end
			fhla_pkg::ST_SCAN_CMP: begin
				state_d = rd_lt ? fhla_pkg::ST_SCAN_RD : fhla_pkg::ST_SHDN_RD;
			end
			fhla_pkg::ST_SHDN_RD: begin
				priority if (idx_nx < count_q) begin
					state_d = fhla_pkg::ST_SHDN_WR;
				end else if (size_q != '0) begin
					state_d = fhla_pkg::ST_PUT_START;
				end else begin
					state_d = fhla_pkg::ST_DONE;
				end
			end
			fhla_pkg::ST_SHDN_WR: state_d = fhla_pkg::ST_SHDN_RD;
			fhla_pkg::ST_DONE: begin
				if (take) begin
					state_d = fhla_pkg::ST_IDLE;
				end
			end
			default: state_d = fhla_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		raddr     = '0;
		we        = 1'b0;
		waddr     = idx_q[IDX_W-1:0];
		wdata     = rd_q;
		stat.idle = (state_q == fhla_pkg::ST_IDLE);
		stat.done = (state_q == fhla_pkg::ST_DONE);
		unique case (state_q)
			fhla_pkg::ST_SRCH_RD: raddr = mid[IDX_W-1:0];
			fhla_pkg::ST_SHUP_RD: begin
				if (idx_q > pos_q) begin
					raddr = IDX_W'(idx_q - 1'b1);
				end
			end
			fhla_pkg::ST_SHUP_WR: we = 1'b1;
			fhla_pkg::ST_PUT_WR: begin
				we    = 1'b1;
				waddr = pos_q[IDX_W-1:0];
				wdata = {off_q, size_q};
			end
			fhla_pkg::ST_SCAN_RD: raddr = idx_q[IDX_W-1:0];
			fhla_pkg::ST_SHDN_RD: begin
				if (idx_nx < count_q) begin
					raddr = idx_nx[IDX_W-1:0];
				end
			end
			fhla_pkg::ST_SHDN_WR: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhla_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fhla_pkg::ST_PUT_WR) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == fhla_pkg::ST_SHDN_RD && !(idx_nx < count_q)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fhla_pkg::ST_IDLE: begin
				if (start) begin
					op_q      <= req.command;
					off_q     <= req.block_offset;
					size_q    <= req.block_size;
					found_q   <= 1'b0;
					dropped_q <= 1'b0;
					res_off_q <= '0;
					idx_q     <= '0;
				end
			end
			fhla_pkg::ST_PUT_START: begin
				lo_q  <= '0;
				hi_q  <= count_q;
				pos_q <= count_q;
				if (full) begin
					dropped_q <= (op_q == fhla_pkg::CMD_RELEASE);
				end
			end
			fhla_pkg::ST_SRCH_RD: begin
				if (lo_q < hi_q) begin
					idx_q <= mid;
				end else begin
					pos_q <= lo_q;
					idx_q <= count_q;
				end
			end
			fhla_pkg::ST_SRCH_CMP: begin
				if (go_right) begin
					lo_q <= idx_nx;
				end else begin
					hi_q <= idx_q;
				end
			end
			fhla_pkg::ST_SHUP_WR: idx_q <= idx_q - 1'b1;
			fhla_pkg::ST_SCAN_CMP: begin
				if (rd_lt) begin
					idx_q <= idx_nx;
				end else begin
					found_q   <= 1'b1;
					res_off_q <= rd_off;
					off_q     <= new_off;
					size_q    <= diff[SIZE_W-1:0];
				end
			end
			fhla_pkg::ST_SHDN_WR: idx_q <= idx_nx;
			default: ;
		endcase
	end

	assign rsp.found         = found_q;
	assign rsp.result_offset = res_off_q;
	assign rsp.dropped       = dropped_q;
	assign rsp.hole_count    = CW'(count_q);

endmodule

// File: src/free_hole_list_allocator.sv
// ----------------------------------------------------------------------------
// free_hole_list_allocator: bounded free hole list with fit-mode placement
// Top level: request and response channels, fit mode register, response
// register, and the list engine that owns the hole memory.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one word per command. A release inserts {block_offset,
//   block_size} at the place that the fit mode picks; an allocate takes
//   the first hole with size >= block_size, returns its offset and reinserts
//   any nonzero remainder. req_stall stays high while a command is worked on.
//   rsp channel: exactly one word per command, in order, from an output
//   register; the engine can take the next command while that word waits.
//   The sequencer and its single memory port set the pace: one list step is
//   a read state followed by a compare or a write state.
//     release:  into an empty list or in first fit, written at the end; when
//               the list is full or the fourth mode code discards it, it ends
//               without a write; otherwise a binary search for the lower bound
//               in best or worst fit, a shift up of the later entries, a write
//     allocate: a linear scan of the holes in order, a shift down of the
//               later entries, then a release of any nonzero remainder
//   The engine can take the next command in the same cycle as the response word shows.
//   Reset clears the hole count, the fit mode (best fit) and the response
//   valid; the memory contents are not cleared and need not be.
//   When rsp_stall holds the response, the finished word stays put; at most
//   one further command completes into the engine and then waits there.
//   cfg_wr_en / cfg_wr_data write the fit mode; write it only while idle.
// ----------------------------------------------------------------------------
module free_hole_list_allocator #(
	parameter int CAPACITY     = fhla_pkg::CAPACITY_DEF,
	parameter int HEADER_BYTES = fhla_pkg::HEADER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  fhla_pkg::fhla_req_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output fhla_pkg::fhla_rsp_t         rsp,
	input  logic                        cfg_wr_en,
	input  logic [fhla_pkg::MODE_W-1:0] cfg_wr_data
);

	logic [fhla_pkg::MODE_W-1:0] fit_mode_q;
	fhla_pkg::fhla_stat_t        stat;
	fhla_pkg::fhla_rsp_t         eng_rsp;
	fhla_pkg::fhla_rsp_t         rsp_q;
	logic                        rsp_valid_q;
	logic                        start;
	logic                        take;

	// Accept a word only while the engine sits idle
	assign req_stall = !stat.idle;
	assign start     = req_valid && !req_stall;

	// Move a finished word into the response register once it is free
	assign take = stat.done && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= fhla_pkg::FIT_BEST;
		end else if (cfg_wr_en) begin
			fit_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the payload while stalled; it only changes on a take
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	fhla_engine #(
		.CAPACITY     (CAPACITY),
		.HEADER_BYTES (HEADER_BYTES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.fit_mode (fit_mode_q),
		.take     (take),
		.stat     (stat),
		.rsp      (eng_rsp)
	);

endmodule

// File: src/fhla_checker.sv
// ----------------------------------------------------------------------------
// fhla_checker: port-level checks for the free hole list allocator
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module fhla_checker #(
	parameter int CAPACITY = fhla_pkg::CAPACITY_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input fhla_pkg::fhla_rsp_t         rsp
);

	localparam int CW = fhla_pkg::COUNT_W;

	// A stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// An accepted command keeps the engine busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken without engine going busy");

	// A new response follows a cycle in which the engine was busy
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without work in progress");

	// A dropped release means the list is at capacity and nothing was found
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped |->
			rsp.hole_count == CW'(CAPACITY) && !rsp.found)
		else $error("dropped release with list not full");

endmodule

bind free_hole_list_allocator fhla_checker #(
	.CAPACITY (CAPACITY)
) u_fhla_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.rsp         (rsp)
);

// File: tb/sv/hole_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hole_list_checker: response predictor and comparator for the hole list
// Watches the request, response and fit mode ports, keeps its own copy of
// the hole list, and compares every response word with the oldest expected.
// ----------------------------------------------------------------------------
module hole_list_checker #(
	parameter int CAPACITY     = fhla_pkg::CAPACITY_DEF,
	parameter int HEADER_BYTES = fhla_pkg::HEADER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  fhla_pkg::fhla_req_t         req,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  fhla_pkg::fhla_rsp_t         rsp,
	input  logic                        cfg_wr_en,
	input  logic [fhla_pkg::MODE_W-1:0] cfg_wr_data,
	output int                          fail_count,
	output int                          words_owed
);
	import fhla_pkg::*;

	logic [OFF_W-1:0]  hole_off [CAPACITY];
	logic [SIZE_W-1:0] hole_len [CAPACITY];
	int unsigned       holes_held;
	logic [MODE_W-1:0] fit;
	fhla_rsp_t         owed_rsps [$];
	fhla_rsp_t         want;
	int                mismatches = 0;

	// lower-bound search, run as is even when the list is not sorted
	function automatic int unsigned slot_for(logic [SIZE_W-1:0] len, bit descending);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		bit          right;
		lo = 0;
		hi = holes_held;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			right = descending ? (hole_len[mid] > len) : (hole_len[mid] < len);
			if (right) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	// returns 1 when the list is full and the hole is lost
	function automatic bit place_hole(logic [OFF_W-1:0] off, logic [SIZE_W-1:0] len);
		int unsigned pos;
		if (holes_held >= CAPACITY) return 1'b1;
		if (holes_held == 0) begin
			pos = 0;
		end else begin
			case (fit)
				FIT_BEST:  pos = slot_for(len, 1'b0);
				FIT_WORST: pos = slot_for(len, 1'b1);
				FIT_FIRST: pos = holes_held;
				default:   return 1'b0;
			endcase
		end
		for (int unsigned i = holes_held; i > pos; i--) begin
			hole_off[i] = hole_off[i-1];
			hole_len[i] = hole_len[i-1];
		end
		hole_off[pos] = off;
		hole_len[pos] = len;
		holes_held++;
		return 1'b0;
	endfunction

	function automatic fhla_rsp_t serve_command(fhla_req_t w);
		fhla_rsp_t        r;
		logic [SIZE_W-1:0] rest;
		logic [OFF_W-1:0]  moved;
		bit               hit;
		r = '0;
		hit = 1'b0;
		if (w.command == CMD_RELEASE) begin
			r.dropped = place_hole(w.block_offset, w.block_size);
		end else begin
			for (int unsigned i = 0; i < holes_held && !hit; i++) begin
				if (hole_len[i] >= w.block_size) begin
					hit = 1'b1;
					rest = hole_len[i] - w.block_size;
					moved = hole_off[i] + OFF_W'(HEADER_BYTES) + w.block_size;
					r.found = 1'b1;
					r.result_offset = hole_off[i];
					for (int unsigned j = i; j + 1 < holes_held; j++) begin
						hole_off[j] = hole_off[j+1];
						hole_len[j] = hole_len[j+1];
					end
					holes_held--;
					if (rest != '0) void'(place_hole(moved, rest));
				end
			end
		end
		r.hole_count = COUNT_W'(holes_held);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected 0x%h, got 0x%h",
				$time, field, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holes_held = 0;
			fit = FIT_BEST;
			owed_rsps.delete();
			words_owed <= 0;
			fail_count <= mismatches;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsps.size() == 0) begin
					$display({"%0t: unexpected response word, expected none, ",
						"got found=%b offset=0x%h dropped=%b count=%0d"},
						$time, rsp.found, rsp.result_offset, rsp.dropped,
						rsp.hole_count);
					mismatches++;
				end else begin
					want = owed_rsps.pop_front();
					check_field("found", 32'(want.found), 32'(rsp.found));
					check_field("result_offset", want.result_offset, rsp.result_offset);
					check_field("dropped", 32'(want.dropped), 32'(rsp.dropped));
					check_field("hole_count", 32'(want.hole_count), 32'(rsp.hole_count));
				end
			end
			if (cfg_wr_en) fit = cfg_wr_data;
			if (req_valid && !req_stall) owed_rsps.push_back(serve_command(req));
			words_owed <= owed_rsps.size();
			fail_count <= mismatches;
		end
	end

endmodule

// File: tb/sv/free_hole_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_hole_list_allocator_tb: stimulus and verdict for the hole list block
// Drives directed and random release/allocate words under every fit mode,
// with random sender gaps and receiver stalls; the checker beside the block
// predicts each response word and counts mismatches.
// ----------------------------------------------------------------------------
module free_hole_list_allocator_tb;
	import fhla_pkg::*;

	// the fourth mode code: nothing is placed into a nonempty list
	localparam logic [MODE_W-1:0] FIT_NONE = 2'd3;
	localparam int DRAIN_CYCLES = 600;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              req_valid   = 1'b0;
	logic              req_stall;
	fhla_req_t         req         = '0;
	logic              rsp_valid;
	logic              rsp_stall   = 1'b0;
	fhla_rsp_t         rsp;
	logic              cfg_wr_en   = 1'b0;
	logic [MODE_W-1:0] cfg_wr_data = '0;

	int fail_count;
	int words_owed;
	int gap_pct   = 0;
	int stall_pct = 0;

	// idle patterns: none, sender only, receiver only, both
	int                phase_gap   [4] = '{0, 60, 0, 19};
	int                phase_stall [4] = '{0, 0, 60, 19};
	logic [MODE_W-1:0] phase_fit   [8] = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_NONE,
		FIT_WORST, FIT_BEST, FIT_FIRST, FIT_BEST};

	free_hole_list_allocator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	hole_list_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.words_owed  (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver side: stall at random, each cycle decided afresh
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Send one word. Drop valid only when a gap is wanted, so back-to-back
	// words keep valid high without a lower/raise pair in one step.
	task automatic send_word(input logic cmd, input logic [OFF_W-1:0] off,
			input logic [SIZE_W-1:0] len);
		if ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		req_valid <= 1'b1;
		req <= '{command: cmd, block_offset: off, block_size: len};
		do @(posedge clk); while (req_stall);
	endtask

	// Hold valid low and wait until every response word has come back.
	// The first edge lets the checker count the word just accepted.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0) @(posedge clk);
	endtask

	// Write the fit mode; only called once the block is idle.
	task automatic write_fit(input logic [MODE_W-1:0] mode);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Size classes: tiny sizes make exact fits (and so list shrinkage)
	// common, mid sizes the usual case, full-width sizes reach every bit.
	function automatic logic [SIZE_W-1:0] pick_len(int tiny_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < tiny_pct) return SIZE_W'($urandom_range(0, 15));
		if (roll < tiny_pct + (100 - tiny_pct) * 6 / 10) return SIZE_W'($urandom_range(0, 4095));
		return SIZE_W'($urandom);
	endfunction

	initial begin
		int  items;
		bit  filling;
		logic cmd;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: best fit after reset
		send_word(CMD_ALLOCATE, 32'h0000_0000, 32'd5);          // empty list, nothing found
		send_word(CMD_RELEASE,  32'h0000_0000, 32'h0000_0000);  // empty list, zero-size hole
		send_word(CMD_RELEASE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);  // extremes of both fields
		send_word(CMD_RELEASE,  32'd100,       32'd50);
		send_word(CMD_RELEASE,  32'd200,       32'd20);
		send_word(CMD_ALLOCATE, 32'hFFFF_FFFF, 32'd0);          // zero request takes the empty hole
		send_word(CMD_ALLOCATE, 32'h5555_AAAA, 32'd0);          // zero request, whole hole reinserted
		send_word(CMD_ALLOCATE, 32'h0000_0000, 32'd30);         // split with a remainder
		send_word(CMD_ALLOCATE, 32'h0000_0000, 32'h8000_0000);  // remainder offset wraps
		send_word(CMD_ALLOCATE, 32'h0000_0000, 32'hFFFF_FFFF);  // too large, not found

		// worst fit on top of a best-fit list
		write_fit(FIT_WORST);
		send_word(CMD_RELEASE,  32'd300, 32'd40);
		send_word(CMD_RELEASE,  32'd400, 32'd4000);
		send_word(CMD_ALLOCATE, 32'd0,   32'd10);

		write_fit(FIT_FIRST);
		send_word(CMD_RELEASE,  32'd500, 32'd7);
		send_word(CMD_ALLOCATE, 32'd0,   32'd7);

		// fourth mode: release into a nonempty list and a remainder both vanish
		write_fit(FIT_NONE);
		send_word(CMD_RELEASE,  32'd600, 32'd9);
		send_word(CMD_ALLOCATE, 32'd0,   32'd1);

		// random phases; the list carries over, so each mode change
		// meets a list ordered by the previous mode
		for (int p = 0; p < 8; p++) begin
			write_fit(phase_fit[p]);
			gap_pct   = phase_gap[p % 4];
			stall_pct = phase_stall[p % 4];
			items = (phase_fit[p] == FIT_NONE) ? 100 : 220;
			for (int n = 0; n < items; n++) begin
				// alternate filling stretches (reach the full list and drops)
				// with draining ones (exact fits shrink the list)
				filling = ((n / 50) % 2) == 0;
				cmd = ($urandom_range(0, 99) < (filling ? 65 : 25)) ? CMD_RELEASE : CMD_ALLOCATE;
				send_word(cmd, OFF_W'($urandom), pick_len(filling ? 35 : 70));
			end
		end

		// drain: wait out the last responses and any late extra word
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && words_owed == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// watchdog: a stuck handshake ends the run as a failure
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
